/* rtl/slu_pkg.sv */
// Package for the sorted list unit: field widths, operation and status
// codes, and the request and result structs used by the cell array, top level and bench.
// No dependencies.
package slu_pkg;

  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned ValueW          = 32;
  localparam int unsigned RankW           = 4;
  localparam int unsigned CountW          = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_RANK  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [ValueW-1:0] value;
    logic [RankW-1:0]         rank;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [ValueW-1:0] read_value;
    logic [CountW-1:0]        entry_count;
  } res_t;

endpackage

/* rtl/slu_if.sv */
// Valid/ready channel interfaces for the sorted list unit: one for the
// operation channel and one for the result channel. Depends on slu_pkg.
interface slu_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         opcode;
  logic signed [slu_pkg::ValueW-1:0]  value;
  logic [slu_pkg::RankW-1:0]          rank;

  modport source (output valid, output opcode, output value, output rank, input ready);
  modport sink   (input valid, input opcode, input value, input rank, output ready);
endinterface

interface slu_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [slu_pkg::ValueW-1:0]  read_value;
  logic [slu_pkg::CountW-1:0]         entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  output ready);
endinterface

/* rtl/slu_cell_array.sv */
// Sorted cell array: the stored entries and count, with the parallel compare
// and shift logic that applies one operation per cycle while op_valid_i is high. Depends on slu_pkg.
module slu_cell_array #(
  parameter int unsigned Capacity = slu_pkg::CapacityDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  slu_pkg::req_t req_i,
  output slu_pkg::res_t res_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic signed [slu_pkg::ValueW-1:0] entries_q [Capacity];
  logic signed [slu_pkg::ValueW-1:0] entries_d [Capacity];
  logic [CntW-1:0]                   count_q, count_d;

  logic [Capacity-1:0] valid;
  logic [Capacity-1:0] ge;
  logic [Capacity-1:0] eq;
  logic [Capacity-1:0] ins_f;
  logic [Capacity-1:0] rem_f;
  logic                full;
  logic                found;
  logic                rank_ok;
  logic signed [slu_pkg::ValueW-1:0] rank_data;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      valid[i] = CntW'(i) < count_q;
      ge[i]    = !(entries_q[i] < req_i.value);
      eq[i]    = entries_q[i] == req_i.value;
      rem_f[i] = valid[i] && ge[i];
    end
    // A value equal to the head goes after it; beyond the head the list
    // shifts from the first cell that is not below the value. Empty cells
    // count as shifting so that an append lands at the count.
    ins_f[0] = valid[0] ? (req_i.value < entries_q[0]) : 1'b1;
    for (int i = 1; i < Capacity; i++) begin
      ins_f[i] = valid[i] ? ge[i] : 1'b1;
    end
    full  = count_q == CntW'(Capacity);
    found = |(valid & eq);

    rank_data = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (int'(req_i.rank) == i) begin
        rank_data = entries_q[i];
      end
    end
    rank_ok = int'(req_i.rank) < int'(count_q);
  end

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      entries_d[i] = entries_q[i];
    end
    count_d           = count_q;
    res_o.status      = slu_pkg::ST_OK;
    res_o.read_value  = '0;

    case (req_i.opcode)
      slu_pkg::OP_INSERT: begin
        if (full) begin
          res_o.status = slu_pkg::ST_FULL;
        end else begin
          entries_d[0] = ins_f[0] ? req_i.value : entries_q[0];
          for (int i = 1; i < Capacity; i++) begin
            if (ins_f[i]) begin
              entries_d[i] = ins_f[i-1] ? entries_q[i-1] : req_i.value;
            end
          end
          count_d = count_q + 1'b1;
        end
      end
      slu_pkg::OP_REMOVE: begin
        if (!found) begin
          res_o.status = slu_pkg::ST_NOT_FOUND;
        end else begin
          // Equal values are contiguous, so the first cell not below the
          // value is the first occurrence.
          for (int i = 0; i < Capacity - 1; i++) begin
            if (rem_f[i]) begin
              entries_d[i] = entries_q[i+1];
            end
          end
          count_d = count_q - 1'b1;
        end
      end
      slu_pkg::OP_READ: begin
        if (rank_ok) begin
          res_o.read_value = rank_data;
        end else begin
          res_o.status = slu_pkg::ST_BAD_RANK;
        end
      end
      default: begin
      end
    endcase

    res_o.entry_count = slu_pkg::CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (op_valid_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_valid_i) begin
      for (int i = 0; i < Capacity; i++) begin
        entries_q[i] <= entries_d[i];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count exceeds capacity");

  a_full_only_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid_i && res_o.status == slu_pkg::ST_FULL |-> count_q == CntW'(Capacity))
    else $error("full status with free cells");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid_i && req_i.opcode == slu_pkg::OP_INSERT && res_o.status == slu_pkg::ST_OK
    |=> count_q == $past(count_q) + 1'b1)
    else $error("successful insert did not grow the list");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid_i && req_i.opcode == slu_pkg::OP_REMOVE && res_o.status == slu_pkg::ST_OK
    |=> count_q == $past(count_q) - 1'b1)
    else $error("successful remove did not shrink the list");

endmodule

/* rtl/sorted_list_insert_remove_unit.sv */
// Top level of the sorted list unit: input register, cell array and result
// register. Depends on slu_pkg, slu_if and slu_cell_array.
//
// Keeps an ascending list of up to Capacity signed 32-bit values, with
// duplicates allowed. Each transaction on in_i carries an opcode (insert,
// remove, read at rank), a value and a rank; each produces exactly one
// transaction on out_o with a status, the value read and the entry count
// after the operation.
//
// A transaction accepted on in_i is held in the input register; the cell
// array then compares the value against every cell at once, shifts the
// cells and updates the count, and the result is registered in the output
// register, from which it is offered on out_o. One operation is taken every
// cycle while out_o does not stall, set by the single compare-and-shift pass
// across the cells.
//
// Reset empties the list; cell contents are not cleared. When out_o stalls,
// the output register holds its result and the input register holds one
// more transaction; in_i.ready then drops until the output is taken.
module sorted_list_insert_remove_unit #(
  parameter int unsigned Capacity = slu_pkg::CapacityDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slu_in_if.sink     in_i,
  slu_out_if.source  out_o
);

  logic          in_vld_q;
  slu_pkg::req_t req_q;
  logic          out_vld_q;
  slu_pkg::res_t res_q;
  slu_pkg::res_t res_d;
  logic          advance;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      req_q.opcode <= in_i.opcode;
      req_q.value  <= in_i.value;
      req_q.rank   <= in_i.rank;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  slu_cell_array #(
    .Capacity (Capacity)
  ) u_cells (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (advance),
    .req_i      (req_q),
    .res_o      (res_d)
  );

  assign out_o.valid       = out_vld_q;
  assign out_o.status      = res_q.status;
  assign out_o.read_value  = res_q.read_value;
  assign out_o.entry_count = res_q.entry_count;

endmodule

/* bench/sorted_list_insert_remove_unit_tb.sv */
// Testbench for sorted_list_insert_remove_unit: drives insert, remove and read
// transactions with random gaps and output stalls, and checks every result
// against its own copy of the list. Depends on slu_pkg, slu_if and the unit.
module sorted_list_insert_remove_unit_tb;
  import slu_pkg::*;

  localparam int unsigned Capacity    = CapacityDefault;
  localparam logic [1:0]  OpUnused    = 2'd3;
  localparam int unsigned RandomItems = 700;
  localparam int unsigned DrainEvery  = 150;
  localparam int unsigned PhaseLen    = 50;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned TailCycles  = 10;

  localparam logic signed [ValueW-1:0] ValueMin = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] ValueMax = 32'sh7FFF_FFFF;

  typedef enum int {StallNone, StallShort, StallLong} stall_mode_e;
  typedef enum int {PhaseFill, PhaseDrain, PhaseMixed} fill_phase_e;

  typedef struct {
    req_t req;
    bit   hold_for_drain;
  } list_op_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  slu_in_if  in_if ();
  slu_out_if out_if ();

  sorted_list_insert_remove_unit #(.Capacity(Capacity)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the list, updated once per accepted transaction.
  logic signed [ValueW-1:0] list_entries [Capacity];
  int                       list_count = 0;

  list_op_t    op_queue[$];
  res_t        expected_results[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic push_op(input logic [1:0] opcode, input logic signed [ValueW-1:0] value,
                         input logic [RankW-1:0] rank, input bit hold_for_drain);
    list_op_t item;
    item.req.opcode     = opcode;
    item.req.value      = value;
    item.req.rank       = rank;
    item.hold_for_drain = hold_for_drain;
    op_queue.push_back(item);
  endtask

  function automatic res_t apply_list_op(input logic [1:0] opcode,
                                         input logic signed [ValueW-1:0] value,
                                         input logic [RankW-1:0] rank);
    res_t res;
    int   pos;
    res.status     = ST_OK;
    res.read_value = '0;
    case (opcode)
      OP_INSERT: begin
        if (list_count >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          // A value equal to the head is placed behind it, so the search
          // below the head only starts at rank one.
          if (list_count == 0 || value < list_entries[0]) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < list_count && list_entries[pos] < value) pos++;
          end
          for (int i = list_count; i > pos; i--) list_entries[i] = list_entries[i-1];
          list_entries[pos] = value;
          list_count++;
        end
      end
      OP_REMOVE: begin
        pos = 0;
        while (pos < list_count && list_entries[pos] != value) pos++;
        if (pos >= list_count) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
          list_count--;
        end
      end
      OP_READ: begin
        if (int'(rank) < list_count && int'(rank) < Capacity) begin
          res.read_value = list_entries[rank];
        end else begin
          res.status = ST_BAD_RANK;
        end
      end
      default: begin
        // The unused opcode leaves the list alone and answers ok.
      end
    endcase
    res.entry_count = CountW'(list_count);
    return res;
  endfunction

  // Driver: bursts of transactions separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    list_op_t item;
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.opcode <= OP_INSERT;
      in_if.value  <= '0;
      in_if.rank   <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(apply_list_op(in_if.opcode, in_if.value, in_if.rank));
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (op_queue.size() > 0 &&
                     !(op_queue[0].hold_for_drain &&
                       (expected_results.size() > 0 || out_if.valid))) begin
          item = op_queue.pop_front();
          in_if.valid  <= 1'b1;
          in_if.opcode <= item.req.opcode;
          in_if.value  <= item.req.value;
          in_if.rank   <= item.req.rank;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result and stalls the output on a changing pattern.
  stall_mode_e stall_mode = StallNone;
  int unsigned mode_cycles = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    res_t exp_res;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: status %0d value %0d count %0d",
                                    out_if.status, out_if.read_value, out_if.entry_count));
        end else begin
          exp_res = expected_results.pop_front();
          if (out_if.status !== exp_res.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_if.status, exp_res.status));
          if (out_if.read_value !== exp_res.read_value)
            report_mismatch($sformatf("read_value %0d, expected %0d",
                                      out_if.read_value, exp_res.read_value));
          if (out_if.entry_count !== exp_res.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      out_if.entry_count, exp_res.entry_count));
        end
      end
      if (mode_cycles == 0) begin
        stall_mode  = stall_mode_e'($urandom_range(0, 2));
        mode_cycles = $urandom_range(32, 128);
      end
      mode_cycles--;
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          StallShort: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
          StallLong:  if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 24);
          default: ;
        endcase
        out_if.ready <= (stall_left == 0);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    fill_phase_e              phase;
    int unsigned              pick;
    logic [1:0]               opcode;
    logic signed [ValueW-1:0] value;
    logic [RankW-1:0]         rank;

    rst_ni = 1'b0;

    // Directed: empty list, unused opcode, extremes, duplicates, full list.
    push_op(OP_REMOVE, 32'sd5, RankW'($urandom_range(0, 15)), 1'b0);
    push_op(OP_READ, $urandom, 4'd0, 1'b0);
    push_op(OpUnused, ValueMin, 4'd15, 1'b0);
    push_op(OP_INSERT, ValueMax, 4'd15, 1'b0);
    push_op(OP_INSERT, ValueMin, 4'd0, 1'b0);
    push_op(OP_INSERT, 32'sd0, RankW'($urandom_range(0, 15)), 1'b0);
    push_op(OP_INSERT, -32'sd1, RankW'($urandom_range(0, 15)), 1'b0);
    push_op(OP_INSERT, 32'sd0, RankW'($urandom_range(0, 15)), 1'b0);
    // Equal to the head, so it goes in behind the head.
    push_op(OP_INSERT, ValueMin, RankW'($urandom_range(0, 15)), 1'b0);
    for (int i = 0; i < Capacity - 6; i++) push_op(OP_INSERT, $urandom, RankW'($urandom), 1'b0);
    push_op(OP_INSERT, 32'sd7, RankW'($urandom_range(0, 15)), 1'b0);
    push_op(OP_READ, $urandom, 4'd0, 1'b0);
    push_op(OP_READ, $urandom, 4'd15, 1'b0);
    push_op(OP_REMOVE, ValueMin, RankW'($urandom_range(0, 15)), 1'b0);
    push_op(OP_REMOVE, 32'sd12345, RankW'($urandom_range(0, 15)), 1'b0);
    push_op(OP_READ, $urandom, 4'd15, 1'b0);
    push_op(OP_REMOVE, ValueMax, RankW'($urandom_range(0, 15)), 1'b0);

    // Random: phases that lean toward filling, draining or a mix, with most
    // values drawn from a narrow range so that removes find their targets.
    phase = PhaseMixed;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % PhaseLen == 0) phase = fill_phase_e'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        opcode = OpUnused;
      end else begin
        case (phase)
          PhaseFill:  opcode = (pick < 65) ? OP_INSERT : (pick < 80) ? OP_REMOVE : OP_READ;
          PhaseDrain: opcode = (pick < 20) ? OP_INSERT : (pick < 75) ? OP_REMOVE : OP_READ;
          default:    opcode = (pick < 40) ? OP_INSERT : (pick < 70) ? OP_REMOVE : OP_READ;
        endcase
      end
      case ($urandom_range(0, 9))
        0:       value = ValueMin;
        1:       value = ValueMax;
        2:       value = $urandom;
        default: value = $signed($urandom_range(0, 8)) - 32'sd4;
      endcase
      rank = ($urandom_range(0, 1) == 0) ? RankW'($urandom_range(0, 3))
                                         : RankW'($urandom_range(0, 15));
      push_op(opcode, value, rank, (n % DrainEvery) == 0);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sampled away from the rising edge so that every update of the edge
    // has settled.
    while (op_queue.size() > 0 || in_if.valid || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
